// File: src/aplf_pkg.sv
// aplf_pkg: shared types and constants for the all-pole recursive line filter.
// Used by aplf_ctrl, aplf_dp and all_pole_recursive_line_filter_top.
package aplf_pkg;

  localparam int SAMPLE_W      = 24;  // Q8.16 sample
  localparam int COEFF_W       = 18;  // Q2.16 coefficient
  localparam int FRAC_W        = 16;
  localparam int TAPS_W        = 3;
  localparam int NUM_COEFF     = 4;
  localparam int MAX_TAPS_DEF  = 4;
  localparam int PROD_W        = SAMPLE_W + COEFF_W;
  // product plus growth for up to seven taps, plus room for x*2^16 - acc + half
  localparam int ACC_W         = PROD_W + 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = COEFF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 3'd0,
    REG_COEFF_0   = 3'd1,
    REG_COEFF_1   = 3'd2,
    REG_COEFF_2   = 3'd3,
    REG_COEFF_3   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;  // take a new sample, clear accumulator
    logic mul;   // multiply one tap into the product register
    logic fin;   // round, clamp, load output, shift history
  } cmd_t;

endpackage

// File: src/all_pole_recursive_line_filter_top.sv
// all_pole_recursive_line_filter_top: config registers, controller and datapath.
// Depends on aplf_pkg, aplf_ctrl, aplf_dp.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_sample_in[23:0], in_line_start
//   out_    | output    | out_valid/out_stall| out_sample_out[23:0], out_saturated
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index[2:0], cfg_data[17:0]
//
// A sample runs: accept, one multiply per tap on the single shared multiplier,
// one accumulate drain (skipped with no taps), one round/clamp into the output reg.
// Taps are min(tap_count, MAX_TAPS). Reset (rst_n low, synchronous) zeroes config and
// history. A result waiting on out_stall holds the block in its finish step; the
// next sample is accepted once that result is in the output register.
module all_pole_recursive_line_filter_top #(
  parameter int MAX_TAPS = aplf_pkg::MAX_TAPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [aplf_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic                                  in_line_start,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [aplf_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                  out_saturated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [aplf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aplf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  logic [aplf_pkg::TAPS_W-1:0]         tap_count_r;
  logic signed [aplf_pkg::COEFF_W-1:0] coeff_r [aplf_pkg::NUM_COEFF];
  logic [aplf_pkg::TAPS_W-1:0]         taps_eff;
  aplf_pkg::cmd_t                      cmd;
  logic [IDX_W-1:0]                    tap_idx;
  logic                                out_free;

  assign cfg_ready = 1'b1;
  assign taps_eff  = (tap_count_r > aplf_pkg::TAPS_W'(MAX_TAPS)) ?
                     aplf_pkg::TAPS_W'(MAX_TAPS) : tap_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= '0;
      for (int i = 0; i < aplf_pkg::NUM_COEFF; i++) begin
        coeff_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        aplf_pkg::REG_TAP_COUNT: tap_count_r <= cfg_data[aplf_pkg::TAPS_W-1:0];
        aplf_pkg::REG_COEFF_0:   coeff_r[0]  <= cfg_data;
        aplf_pkg::REG_COEFF_1:   coeff_r[1]  <= cfg_data;
        aplf_pkg::REG_COEFF_2:   coeff_r[2]  <= cfg_data;
        aplf_pkg::REG_COEFF_3:   coeff_r[3]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  aplf_ctrl #(
    .MAX_TAPS (MAX_TAPS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .taps_eff (taps_eff),
    .out_free (out_free),
    .cmd      (cmd),
    .tap_idx  (tap_idx)
  );

  aplf_dp #(
    .MAX_TAPS (MAX_TAPS),
    .IDX_W    (IDX_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .tap_idx        (tap_idx),
    .coeff          (coeff_r),
    .in_sample_in   (in_sample_in),
    .in_line_start  (in_line_start),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out),
    .out_saturated  (out_saturated),
    .out_free       (out_free)
  );

endmodule

// File: src/aplf_ctrl.sv
// aplf_ctrl: sample sequencer: accept, a multiply per tap, drain if taps, finish.
// Depends on aplf_pkg (state_t, cmd_t, TAPS_W).
module aplf_ctrl #(
  parameter int MAX_TAPS = aplf_pkg::MAX_TAPS_DEF,
  parameter int IDX_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [aplf_pkg::TAPS_W-1:0] taps_eff,
  input  logic                        out_free,
  output aplf_pkg::cmd_t              cmd,
  output logic [IDX_W-1:0]            tap_idx
);

  aplf_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             last_tap;

  assign tap_idx  = cnt_r;
  assign last_tap = (aplf_pkg::TAPS_W'(cnt_r) == (taps_eff - aplf_pkg::TAPS_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aplf_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      aplf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = (taps_eff == '0) ? aplf_pkg::ST_FIN : aplf_pkg::ST_MUL;
        end
      end
      aplf_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        if (last_tap) begin
          state_nxt = aplf_pkg::ST_ACC;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      aplf_pkg::ST_ACC: begin
        // last product lands in the accumulator
        state_nxt = aplf_pkg::ST_FIN;
      end
      aplf_pkg::ST_FIN: begin
        if (out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = aplf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = aplf_pkg::ST_IDLE;
      end
    endcase
  end

  a_mul_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aplf_pkg::ST_MUL) |-> (aplf_pkg::TAPS_W'(cnt_r) < taps_eff))
    else $error("tap counter ran past tap count");

  a_acc_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aplf_pkg::ST_ACC) |=> (state_r == aplf_pkg::ST_FIN))
    else $error("drain cycle not followed by finish");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aplf_pkg::ST_FIN && !out_free) |=> (state_r == aplf_pkg::ST_FIN))
    else $error("finish left while output register busy");

endmodule

// File: src/aplf_dp.sv
// aplf_dp: history line, shared multiply-accumulate, round/clamp and output register.
// Depends on aplf_pkg (cmd_t, widths).
module aplf_dp #(
  parameter int MAX_TAPS = aplf_pkg::MAX_TAPS_DEF,
  parameter int IDX_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  aplf_pkg::cmd_t                       cmd,
  input  logic [IDX_W-1:0]                     tap_idx,
  input  logic signed [aplf_pkg::COEFF_W-1:0]  coeff [aplf_pkg::NUM_COEFF],
  input  logic signed [aplf_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                 in_line_start,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [aplf_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                 out_saturated,
  output logic                                 out_free
);

  localparam int SW = aplf_pkg::SAMPLE_W;
  localparam int AW = aplf_pkg::ACC_W;
  localparam logic signed [AW-1:0] Y_MAX = (AW'(1) << (SW - 1)) - AW'(1);
  localparam logic signed [AW-1:0] Y_MIN = -(AW'(1) << (SW - 1));
  localparam logic signed [AW-1:0] HALF  = AW'(1) << (aplf_pkg::FRAC_W - 1);

  logic signed [SW-1:0]                hist_r [MAX_TAPS];
  logic signed [aplf_pkg::COEFF_W-1:0] coeff_ext [MAX_TAPS];
  logic signed [SW-1:0]                x_r;
  logic signed [aplf_pkg::PROD_W-1:0]  prod_r;
  logic                                prod_v_r;
  logic signed [AW-1:0]                acc_r;
  logic                                out_valid_r;
  logic signed [SW-1:0]                out_sample_r;
  logic                                out_sat_r;

  logic signed [AW-1:0] diff;
  logic signed [AW-1:0] y_wide;
  logic signed [SW-1:0] y_clamp;
  logic                 y_sat;
  logic                 hist_nz;

  // taps past the last coefficient register weigh zero
  for (genvar g = 0; g < MAX_TAPS; g++) begin : g_coeff
    if (g < aplf_pkg::NUM_COEFF) begin : g_reg
      assign coeff_ext[g] = coeff[g];
    end else begin : g_zero
      assign coeff_ext[g] = '0;
    end
  end

  assign diff   = (AW'(x_r) <<< aplf_pkg::FRAC_W) - acc_r + HALF;
  assign y_wide = diff >>> aplf_pkg::FRAC_W;

  always_comb begin
    y_sat   = 1'b0;
    y_clamp = y_wide[SW-1:0];
    if (y_wide > Y_MAX) begin
      y_clamp = Y_MAX[SW-1:0];
      y_sat   = 1'b1;
    end else if (y_wide < Y_MIN) begin
      y_clamp = Y_MIN[SW-1:0];
      y_sat   = 1'b1;
    end
  end

  always_comb begin
    hist_nz = 1'b0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      hist_nz = hist_nz | (hist_r[i] != '0);
    end
  end

  assign out_free       = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_r[i] <= '0;
      end
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prod_v_r <= cmd.mul;
      if (cmd.load && in_line_start) begin
        for (int i = 0; i < MAX_TAPS; i++) begin
          hist_r[i] <= '0;
        end
      end else if (cmd.fin) begin
        for (int i = MAX_TAPS - 1; i > 0; i--) begin
          hist_r[i] <= hist_r[i-1];
        end
        hist_r[0] <= y_clamp;
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_sample_in;
    end
    if (cmd.mul) begin
      prod_r <= coeff_ext[tap_idx] * hist_r[tap_idx];
    end
    if (cmd.load) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + AW'(prod_r);
    end
    if (cmd.fin) begin
      out_sample_r <= y_clamp;
      out_sat_r    <= y_sat;
    end
  end

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid_r)
    else $error("finished sample did not reach output register");

  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && in_line_start) |=> !hist_nz)
    else $error("line start did not clear history");

  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && y_sat) |=>
      (out_sample_r == Y_MAX[SW-1:0] || out_sample_r == Y_MIN[SW-1:0]))
    else $error("saturated beat not at a rail");

endmodule

// File: tb/sv/aplf_checker.sv
// aplf_checker: watches the sample, result and config channels of the all-pole line filter,
// predicts each filtered sample and compares it with the result beats.
// Depends on aplf_pkg.
module aplf_checker #(
  parameter int MAX_TAPS = aplf_pkg::MAX_TAPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [aplf_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic                                  in_line_start,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [aplf_pkg::SAMPLE_W-1:0]  out_sample_out,
  input  logic                                  out_saturated,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [aplf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [aplf_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                    fail_count,
  output int                                    pending
);

  typedef struct packed {
    logic signed [aplf_pkg::SAMPLE_W-1:0] sample;
    logic                                 sat;
  } filt_res_t;

  localparam longint SAMPLE_HI = (longint'(1) <<< (aplf_pkg::SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_LO = -(longint'(1) <<< (aplf_pkg::SAMPLE_W - 1));

  logic [aplf_pkg::TAPS_W-1:0]          taps_cfg;
  logic signed [aplf_pkg::COEFF_W-1:0]  coeff_cfg [aplf_pkg::NUM_COEFF];
  logic signed [aplf_pkg::SAMPLE_W-1:0] y_hist [MAX_TAPS];
  filt_res_t                            filtered_q [$];

  always @(posedge clk) begin : watch
    int        n_taps;
    longint    acc;
    longint    y;
    filt_res_t pred;
    filt_res_t want;
    if (!rst_n) begin
      taps_cfg = '0;
      for (int i = 0; i < aplf_pkg::NUM_COEFF; i++) coeff_cfg[i] = '0;
      for (int i = 0; i < MAX_TAPS; i++) y_hist[i] = '0;
      filtered_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (aplf_pkg::cfg_reg_t'(cfg_index))
          aplf_pkg::REG_TAP_COUNT: taps_cfg = cfg_data[aplf_pkg::TAPS_W-1:0];
          aplf_pkg::REG_COEFF_0:   coeff_cfg[0] = cfg_data;
          aplf_pkg::REG_COEFF_1:   coeff_cfg[1] = cfg_data;
          aplf_pkg::REG_COEFF_2:   coeff_cfg[2] = cfg_data;
          aplf_pkg::REG_COEFF_3:   coeff_cfg[3] = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (in_line_start)
          for (int i = 0; i < MAX_TAPS; i++) y_hist[i] = '0;
        n_taps = (taps_cfg > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
        acc = 0;
        for (int t = 0; t < n_taps; t++)
          if (t < aplf_pkg::NUM_COEFF)
            acc += longint'(coeff_cfg[t]) * longint'(y_hist[t]);
        // round half up to Q8.16: add half an LSB, then floor
        y = (longint'(in_sample_in) <<< aplf_pkg::FRAC_W) - acc +
            (longint'(1) <<< (aplf_pkg::FRAC_W - 1));
        y = y >>> aplf_pkg::FRAC_W;
        pred.sat = 1'b0;
        if (y > SAMPLE_HI) begin
          y = SAMPLE_HI;
          pred.sat = 1'b1;
        end else if (y < SAMPLE_LO) begin
          y = SAMPLE_LO;
          pred.sat = 1'b1;
        end
        pred.sample = y[aplf_pkg::SAMPLE_W-1:0];
        for (int i = MAX_TAPS - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
        y_hist[0] = pred.sample;
        filtered_q.push_back(pred);
      end

      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $error("result beat with none expected: sample_out %0d saturated %0b",
                 out_sample_out, out_saturated);
          fail_count++;
        end else begin
          want = filtered_q.pop_front();
          if (out_sample_out !== want.sample) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want.sample,
                   out_sample_out);
            fail_count++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated mismatch: expected %0b, actual %0b", want.sat, out_saturated);
            fail_count++;
          end
        end
      end
      pending <= filtered_q.size();
    end
  end

endmodule

// File: tb/sv/tb_all_pole_recursive_line_filter_top.sv
// tb_all_pole_recursive_line_filter_top: stimulus and verdict for the all-pole line filter.
// Depends on aplf_pkg, all_pole_recursive_line_filter_top and aplf_checker.
module tb_all_pole_recursive_line_filter_top;

  localparam int CLK_PERIOD     = 12;
  localparam int RST_CYCLES     = 9;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RUN_CYCLES_MAX = 600000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_BEATS    = 125;

  localparam logic [aplf_pkg::CFG_IDX_W-1:0]       REG_SPARE_FIRST = 3'd5;
  localparam logic [aplf_pkg::CFG_IDX_W-1:0]       REG_SPARE_LAST  = 3'd7;
  localparam logic signed [aplf_pkg::SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [aplf_pkg::SAMPLE_W-1:0] S_MIN = 24'sh800000;
  localparam logic signed [aplf_pkg::COEFF_W-1:0]  C_MAX = 18'sh1FFFF;
  localparam logic signed [aplf_pkg::COEFF_W-1:0]  C_MIN = 18'sh20000;
  localparam logic signed [aplf_pkg::COEFF_W-1:0]  C_HALF = 18'sh08000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_stall;
  logic signed [aplf_pkg::SAMPLE_W-1:0]  in_sample_in;
  logic                                  in_line_start;
  logic                                  out_valid;
  logic                                  out_stall;
  logic signed [aplf_pkg::SAMPLE_W-1:0]  out_sample_out;
  logic                                  out_saturated;
  logic                                  cfg_valid;
  logic                                  cfg_ready;
  logic [aplf_pkg::CFG_IDX_W-1:0]        cfg_index;
  logic [aplf_pkg::CFG_DATA_W-1:0]       cfg_data;

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;

  all_pole_recursive_line_filter_top u_top (.*);

  aplf_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #(CLK_PERIOD * RUN_CYCLES_MAX);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [aplf_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3, 4: return aplf_pkg::SAMPLE_W'($urandom_range(0, 2 * 65536) - 65536);
      default: return aplf_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [aplf_pkg::COEFF_W-1:0] pick_coeff();
    case ($urandom_range(9))
      0:       return C_MAX;
      1:       return C_MIN;
      2, 3, 4: return aplf_pkg::COEFF_W'($urandom);
      default: return aplf_pkg::COEFF_W'($urandom_range(0, 80000) - 40000);
    endcase
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 73; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default:       begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  // one sample beat; idle cycles before it carry junk payload
  task automatic send_sample(input logic signed [aplf_pkg::SAMPLE_W-1:0] s,
                             input logic ls);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid      <= 1'b0;
      in_sample_in  <= aplf_pkg::SAMPLE_W'($urandom);
      in_line_start <= 1'($urandom);
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_sample_in  <= s;
    in_line_start <= ls;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic cfg_write(input logic [aplf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [aplf_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits of the tap count write are junk
  task automatic load_filter(input logic [aplf_pkg::TAPS_W-1:0] taps,
                             input logic signed [aplf_pkg::COEFF_W-1:0] c0,
                             input logic signed [aplf_pkg::COEFF_W-1:0] c1,
                             input logic signed [aplf_pkg::COEFF_W-1:0] c2,
                             input logic signed [aplf_pkg::COEFF_W-1:0] c3);
    cfg_write(aplf_pkg::REG_TAP_COUNT,
              {(aplf_pkg::CFG_DATA_W - aplf_pkg::TAPS_W)'($urandom), taps});
    cfg_write(aplf_pkg::REG_COEFF_0, c0);
    cfg_write(aplf_pkg::REG_COEFF_1, c1);
    cfg_write(aplf_pkg::REG_COEFF_2, c2);
    cfg_write(aplf_pkg::REG_COEFF_3, c3);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int                            sent;
    int                            line_len;
    logic                          ls;
    logic [aplf_pkg::TAPS_W-1:0]   taps;
    in_valid      <= 1'b0;
    in_sample_in  <= '0;
    in_line_start <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    rst_n         <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unmapped indexes must not disturb anything
    for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++)
      cfg_write(aplf_pkg::CFG_IDX_W'(idx), aplf_pkg::CFG_DATA_W'($urandom));

    // reset config, no line start yet: pass-through
    set_idle(IDLE_NONE);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(-24'sd1, 1'b0);
    wait_drained();

    // negative weights at full scale: runs into both clamps
    load_filter(3'd4, C_MIN, C_MIN, C_MIN, C_MIN);
    send_sample(S_MAX, 1'b1);
    repeat (3) send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b1);
    repeat (3) send_sample(S_MIN, 1'b0);
    wait_drained();

    // tap count above the tap limit, positive weights: oscillates into the clamps
    load_filter(3'd7, C_MAX, C_MAX, C_MAX, C_MAX);
    send_sample(24'sd4000000, 1'b1);
    repeat (5) send_sample('0, 1'b0);
    wait_drained();

    // exact half-LSB feedback: round half up in both signs
    load_filter(3'd1, C_HALF, '0, '0, '0);
    send_sample(24'sd1, 1'b1);
    send_sample('0, 1'b0);
    send_sample(-24'sd1, 1'b1);
    send_sample('0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       taps = 3'd0;
        1:       taps = 3'd7;
        2:       taps = 3'd4;
        default: taps = aplf_pkg::TAPS_W'($urandom_range(7));
      endcase
      if (ph == 3)
        load_filter(taps, C_MAX, C_MIN, C_MAX, C_MIN);
      else
        load_filter(taps, pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
      set_idle(idle_mode_t'(ph % 4));
      sent = 0;
      while (sent < PHASE_BEATS) begin
        line_len = $urandom_range(1, 40);
        for (int j = 0; j < line_len && sent < PHASE_BEATS; j++) begin
          // mostly clean lines; a few stray starts or a missing start
          ls = (j == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
          send_sample(pick_sample(), ls);
          sent++;
          if (ph == 4 && sent == 40 && hold_cycles == 0) hold_cycles = LONG_HOLD;
          if (ph == 6 && sent == 60) wait_drained();
        end
      end
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/aplf_pkg.sv
src/aplf_ctrl.sv
src/aplf_dp.sv
src/all_pole_recursive_line_filter_top.sv
tb/sv/aplf_checker.sv
tb/sv/tb_all_pole_recursive_line_filter_top.sv
